// File: hdl/bdc_pkg.sv
// Braille dot canvas: shared types, codes, constants and helper functions.
// No dependencies; bdc_csr, bdc_engine, the top level and the bench import this package.
package bdc_pkg;

   // item modes
   localparam logic [1:0] MODE_DOT = 2'd0;
   localparam logic [1:0] MODE_BAR = 2'd1;
   localparam logic [1:0] MODE_ROW = 2'd2;

   // register indexes (paddr[2])
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int          PADDR_W      = 3;
   localparam logic [6:0]  WIDTH_RESET  = 7'd64;
   localparam logic [5:0]  HEIGHT_RESET = 6'd32;

   localparam logic [15:0] BRAILLE_BASE = 16'h2800;
   localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;
   localparam logic [5:0]  UTF8_LOW6    = 6'h3F;

   // dot numbers: left column 1,2,3,7 / right column 4,5,6,8, top to bottom
   localparam logic [3:0] DOT_NUMBER [2][4] = '{'{4'd1, 4'd2, 4'd3, 4'd7},
                                                '{4'd4, 4'd5, 4'd6, 4'd8}};

   typedef struct packed {
      logic [6:0] col_count;
      logic [5:0] row_count;
   } cfg_type;

   typedef struct packed {
      logic               psel;
      logic               penable;
      logic               pwrite;
      logic [PADDR_W-1:0] paddr;
      logic [31:0]        pwdata;
   } apb_req_type;

   typedef struct packed {
      logic [7:0] lead_byte;
      logic [7:0] mid_byte;
      logic [7:0] tail_byte;
   } utf8_type;

   function automatic logic [7:0] dot_mask(logic col, logic [1:0] row);
      logic [3:0] d;
      d = DOT_NUMBER[col][row];
      return 8'b1 << (d - 4'd1);
   endfunction

   // the k lowest dots of one column
   function automatic logic [7:0] bar_mask(logic col, logic [2:0] k);
      logic [7:0] m;
      m = '0;
      for (int r = 0; r < 4; r++) begin
         if (3'(4 - r) <= k) begin
            m = m | dot_mask(col, 2'(r));
         end
      end
      return m;
   endfunction

   function automatic utf8_type braille_utf8(logic [7:0] mask);
      logic [15:0] cp;
      utf8_type    u;
      cp = BRAILLE_BASE + 16'(mask);
      u.lead_byte = UTF8_LEAD3 | 8'(cp[15:12]);
      u.mid_byte  = UTF8_CONT | 8'(cp[11:6] & UTF8_LOW6);
      u.tail_byte = UTF8_CONT | 8'(cp[5:0] & UTF8_LOW6);
      return u;
   endfunction

endpackage

// File: hdl/bdc_channels.sv
// Braille dot canvas: valid/ready channel interfaces for request and response items.
// No dependencies.
interface bdc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [5:0] cell_x;
   logic [4:0] cell_y;
   logic       dot_col;
   logic [1:0] dot_row;
   logic [7:0] bar_height;

   modport source (output valid, mode, cell_x, cell_y, dot_col, dot_row, bar_height,
                   input ready);
   modport sink   (input valid, mode, cell_x, cell_y, dot_col, dot_row, bar_height,
                   output ready);
endinterface

interface bdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lead_byte;
   logic [7:0] mid_byte;
   logic [7:0] tail_byte;
   logic [5:0] column;
   logic       last;

   modport source (output valid, lead_byte, mid_byte, tail_byte, column, last,
                   input ready);
   modport sink   (input valid, lead_byte, mid_byte, tail_byte, column, last,
                    output ready);
endinterface

// File: hdl/bdc_csr.sv
// Braille dot canvas: APB-style register file for the column and row counts.
// Depends on bdc_pkg.
module bdc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  bdc_pkg::apb_req_type apb,
   output logic [31:0]          prdata,
   output bdc_pkg::cfg_type     cfg
);
   import bdc_pkg::*;

   logic [6:0] width_ff,  width_in;
   logic [5:0] height_ff, height_in;
   logic       wr_en;

   assign wr_en = apb.psel && apb.penable && apb.pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (apb.paddr[2])
            REG_WIDTH:  width_in  = apb.pwdata[6:0];
            REG_HEIGHT: height_in = apb.pwdata[5:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // byte lanes below bit 2 are ignored
   always_comb begin
      case (apb.paddr[2])
         REG_WIDTH:  prdata = {25'd0, width_ff};
         REG_HEIGHT: prdata = {26'd0, height_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.col_count = width_ff;
   assign cfg.row_count = height_ff;

endmodule

// File: hdl/bdc_cell_ram.sv
// Braille dot canvas: single-port cell memory with a registered read.
// No dependencies.
module bdc_cell_ram #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);
   logic [7:0] cells_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         cells_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= cells_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/bdc_engine.sv
// Braille dot canvas: sequencer for clearing, dot/bar read-modify-write and row render.
// Depends on bdc_pkg, bdc_channels (bdc_req_if, bdc_rsp_if) and the cell memory ports.
module bdc_engine #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 32,
   parameter int DEPTH      = 2048,
   parameter int ADDR_W     = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  bdc_pkg::cfg_type  cfg,
   bdc_req_if.sink           req,
   bdc_rsp_if.source         rsp,
   output logic              mem_we,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_addr,
   output logic [7:0]        mem_wdata,
   input  logic [7:0]        mem_rdata
);
   import bdc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CLEAR   = 6'b000010,
      ST_RMW_RD  = 6'b000100,
      ST_RMW_WR  = 6'b001000,
      ST_REN_RD  = 6'b010000,
      ST_REN_OUT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [5:0]        x_ff, x_in;
   logic [5:0]        y_ff, y_in;
   logic              col_ff, col_in;
   logic [7:0]        mask_ff, mask_in;
   logic [5:0]        full_ff, full_in;   // whole cells still to fill
   logic [1:0]        part_ff, part_in;   // dots in the top partial cell
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        lead_ff, mid_ff, tail_ff;
   logic [5:0]        column_ff;
   logic              last_ff;

   logic [6:0] used_w;
   logic [5:0] used_h;
   logic [7:0] bar_lim, bar_n;
   logic       accept, slot_free, is_last, load_out;
   logic [5:0] addr_x, addr_y;
   utf8_type   utf;

   always_comb begin
      used_w = (cfg.col_count < 7'(MAX_WIDTH)) ? cfg.col_count : 7'(MAX_WIDTH);
      used_h = (9'(cfg.row_count) < 9'(MAX_HEIGHT)) ? cfg.row_count
                                                   : 6'(MAX_HEIGHT);
      bar_lim = {used_h, 2'b00};
      bar_n   = (req.bar_height < bar_lim) ? req.bar_height : bar_lim;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign is_last   = ({1'b0, x_ff} == (used_w - 7'd1));
   assign utf       = braille_utf8(mem_rdata);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      mask_in      = mask_ff;
      full_in      = full_ff;
      part_in      = part_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      load_out     = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = mem_rdata | mask_ff;
      addr_x       = x_ff;
      addr_y       = y_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req.mode)
                  MODE_DOT: begin
                     if (({1'b0, req.cell_x} < used_w) && ({1'b0, req.cell_y} < used_h)) begin
                        x_in     = req.cell_x;
                        y_in     = {1'b0, req.cell_y};
                        mask_in  = dot_mask(req.dot_col, req.dot_row);
                        full_in  = '0;
                        part_in  = '0;
                        state_in = ST_RMW_RD;
                     end
                  end
                  MODE_BAR: begin
                     if (({1'b0, req.cell_x} < used_w) && (bar_n != 8'd0)) begin
                        x_in     = req.cell_x;
                        y_in     = used_h - 6'd1;
                        col_in   = req.dot_col;
                        state_in = ST_RMW_RD;
                        if (bar_n[7:2] != 6'd0) begin
                           mask_in = bar_mask(req.dot_col, 3'd4);
                           full_in = bar_n[7:2] - 6'd1;
                           part_in = bar_n[1:0];
                        end else begin
                           mask_in = bar_mask(req.dot_col, {1'b0, bar_n[1:0]});
                           full_in = '0;
                           part_in = '0;
                        end
                     end
                  end
                  MODE_ROW: begin
                     if (({1'b0, req.cell_y} < used_h) && (used_w != 7'd0)) begin
                        x_in     = '0;
                        y_in     = {1'b0, req.cell_y};
                        state_in = ST_REN_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RMW_RD: begin
            mem_re   = 1'b1;
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            mem_we = 1'b1;
            if (full_ff != 6'd0) begin
               mask_in  = bar_mask(col_ff, 3'd4);
               full_in  = full_ff - 6'd1;
               y_in     = y_ff - 6'd1;
               state_in = ST_RMW_RD;
            end else if (part_ff != 2'd0) begin
               mask_in  = bar_mask(col_ff, {1'b0, part_ff});
               part_in  = '0;
               y_in     = y_ff - 6'd1;
               state_in = ST_RMW_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REN_RD: begin
            mem_re   = 1'b1;
            state_in = ST_REN_OUT;
         end
         ST_REN_OUT: begin
            if (slot_free) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next cell while this one goes out
                  x_in   = x_ff + 6'd1;
                  addr_x = x_ff + 6'd1;
                  mem_re = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign mem_addr = (state_ff == ST_CLEAR) ? clr_ff
                   : ADDR_W'(int'(addr_y) * MAX_WIDTH + int'(addr_x));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      col_ff  <= col_in;
      mask_ff <= mask_in;
      full_ff <= full_in;
      part_ff <= part_in;
      if (load_out) begin
         lead_ff   <= utf.lead_byte;
         mid_ff    <= utf.mid_byte;
         tail_ff   <= utf.tail_byte;
         column_ff <= x_ff;
         last_ff   <= is_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.lead_byte = lead_ff;
   assign rsp.mid_byte  = mid_ff;
   assign rsp.tail_byte = tail_ff;
   assign rsp.column    = column_ff;
   assign rsp.last      = last_ff;

   // write-back hits the entry that was just read
   a_rmw_same_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RMW_WR |-> $past(state_ff) == ST_RMW_RD && $past(mem_addr) == mem_addr)
      else $error("read-modify-write address moved");

   // no memory write while a row is being rendered
   a_no_write_render: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REN_RD || state_ff == ST_REN_OUT) |-> !mem_we)
      else $error("cell write during render");

   // the last cell of a row ends the render
   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REN_OUT && slot_free && is_last |=> state_ff == ST_IDLE && rsp.last)
      else $error("render did not end on the last cell");

   // the clearing pass hands over to idle once it reaches the top entry
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && clr_ff == ADDR_W'(DEPTH - 1) |=> state_ff == ST_IDLE)
      else $error("clearing pass overran");

endmodule

// File: hdl/braille_dot_canvas.sv
// Braille dot canvas top level: register file, cell memory and sequencer.
// Depends on bdc_pkg, bdc_channels, bdc_csr, bdc_cell_ram and bdc_engine.
//
// The canvas is a grid of MAX_WIDTH x MAX_HEIGHT braille cells (8 dots each) held
// in one single-port memory, cell (x, y) at address y*MAX_WIDTH + x. After reset
// the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells (2048 with the
// default sizes), one cell a cycle, and takes no request item until it ends;
// register writes are taken during the pass. Item cost is set by the one memory
// port: a dot item (mode 0) reads its cell, then writes it back; a bar item
// (mode 1) does one read and one write per touched cell, ceil(n/4) cells for n
// the clamped bar height; a row render (mode 2) reads the w used columns, one cell
// per cycle while the response slot is free, and emits one response item per cell
// with last set on the final one. Out-of-range and unused-mode items are taken and
// change nothing. The response register lets a new request item be taken while
// the final response of a row still waits. The column count and row count
// registers live at byte addresses 0 and 4; they are used clamped to MAX_WIDTH
// and MAX_HEIGHT and should be changed only while the block is idle.
module braille_dot_canvas #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   bdc_req_if.sink                     req,
   bdc_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bdc_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import bdc_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   apb_req_type       apb;
   cfg_type           cfg;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata, mem_rdata;

   // registers never stall the bus
   assign pready = 1'b1;

   assign apb.psel    = psel;
   assign apb.penable = penable;
   assign apb.pwrite  = pwrite;
   assign apb.paddr   = paddr;
   assign apb.pwdata  = pwdata;

   bdc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .apb    (apb),
      .prdata (prdata),
      .cfg    (cfg)
   );

   // cell store; read data is registered
   bdc_cell_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // clear pass, dot/bar read-modify-write, row render and response register
   bdc_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .rsp       (rsp),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

// File: test/braille_dot_canvas_tb.sv
// Self-checking bench for braille_dot_canvas. It draws dots and bars at random,
// renders rows and checks every glyph against its own canvas predictor.
// Depends on bdc_pkg, bdc_channels and the braille_dot_canvas RTL.
module braille_dot_canvas_tb;
   import bdc_pkg::*;

   localparam int MAX_W = 64;
   localparam int MAX_H = 32;
   // worst single item: a bar over 32 cells or a row of 64 cells
   localparam int DRAIN_CYCLES = 80;
   // no handshake at all for this long means a hang; covers the clear of 2048 cells
   localparam int QUIET_LIMIT = 10000;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, block drops it

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] cell_x;
      logic [4:0] cell_y;
      logic       dot_col;
      logic [1:0] dot_row;
      logic [7:0] bar_height;
   } canvas_cmd_type;

   typedef struct packed {
      logic [7:0] lead_byte;
      logic [7:0] mid_byte;
      logic [7:0] tail_byte;
      logic [5:0] column;
      logic       last;
   } glyph_type;

   // Canvas predictor plus the queue of glyphs still owed by the block.
   class canvas_board_type;
      logic [7:0] dots [MAX_W*MAX_H];
      logic [6:0] col_count;
      logic [5:0] row_count;
      glyph_type  glyphs_due [$];
      int         errors, n_dot, n_bar, n_row, n_ignored, n_glyphs;

      function new();
         foreach (dots[a]) dots[a] = '0;
         col_count = WIDTH_RESET;
         row_count = HEIGHT_RESET;
         errors = 0; n_dot = 0; n_bar = 0; n_row = 0; n_ignored = 0; n_glyphs = 0;
      endfunction

      function int used_w();
         return (col_count < MAX_W) ? col_count : MAX_W;
      endfunction

      function int used_h();
         return (row_count < MAX_H) ? row_count : MAX_H;
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         if (idx == REG_WIDTH) begin
            col_count = data[6:0];
         end else begin
            row_count = data[5:0];
         end
      endfunction

      function void plot(int x, int y, logic col, logic [1:0] row);
         logic [3:0] d;
         d = DOT_NUMBER[col][row];
         dots[y*MAX_W + x] |= 8'(1) << (d - 1);
      endfunction

      function void note_input(canvas_cmd_type c);
         int          w, h, n;
         logic [15:0] cp;
         glyph_type   g;
         w = used_w();
         h = used_h();
         case (c.mode)
            MODE_DOT: begin
               if (c.cell_x < w && c.cell_y < h) begin
                  plot(c.cell_x, c.cell_y, c.dot_col, c.dot_row);
                  n_dot++;
               end else begin
                  n_ignored++;
               end
            end
            MODE_BAR: begin
               if (c.cell_x < w) begin
                  // bar grows from the bottom dot row of the bottom used cell
                  n = (c.bar_height < 4*h) ? c.bar_height : 4*h;
                  for (int p = 0; p < n; p++) begin
                     plot(c.cell_x, h - 1 - p/4, c.dot_col, 2'(3 - p%4));
                  end
                  n_bar++;
               end else begin
                  n_ignored++;
               end
            end
            MODE_ROW: begin
               if (c.cell_y < h && w > 0) begin
                  for (int x = 0; x < w; x++) begin
                     cp = BRAILLE_BASE + 16'(dots[c.cell_y*MAX_W + x]);
                     g.lead_byte = UTF8_LEAD3 | 8'(cp[15:12]);
                     g.mid_byte  = UTF8_CONT | {2'b00, cp[11:6]};
                     g.tail_byte = UTF8_CONT | {2'b00, cp[5:0]};
                     g.column    = 6'(x);
                     g.last      = (x == w - 1);
                     glyphs_due = {glyphs_due, g};
                  end
                  n_row++;
               end else begin
                  n_ignored++;
               end
            end
            default: n_ignored++;
         endcase
      endfunction

      function void check_result(glyph_type got);
         glyph_type want;
         if (glyphs_due.size() == 0) begin
            $display("%0t: unexpected glyph, actual %h %h %h column %0d last %b", $time,
                     got.lead_byte, got.mid_byte, got.tail_byte, got.column, got.last);
            errors++;
            return;
         end
         want = glyphs_due.pop_front();
         if (got !== want) begin
            $display({"%0t: glyph mismatch, expected %h %h %h column %0d last %b, ",
                      "actual %h %h %h column %0d last %b"},
                     $time, want.lead_byte, want.mid_byte, want.tail_byte, want.column,
                     want.last, got.lead_byte, got.mid_byte, got.tail_byte, got.column,
                     got.last);
            errors++;
         end else begin
            n_glyphs++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel, penable, pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [31:0]          pwdata, prdata;
   logic                 pready;

   bdc_req_if req ();
   bdc_rsp_if rsp ();

   canvas_board_type board;
   int               burst_left;
   int               quiet = 0;
   glyph_type        seen;
   canvas_cmd_type   taken;

   // size settings for the random phases: clamped, minimal and zero sizes included
   int phase_w     [8] = '{127, 1, 0, 64, 24, 5, 64, 40};
   int phase_h     [8] = '{63, 1, 5, 0, 12, 32, 32, 3};
   int phase_items [8] = '{45, 30, 15, 15, 45, 40, 45, 30};

   always #1 clock = ~clock;

   braille_dot_canvas #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Handshakes are sampled at the clock edge. A glyph is checked before a new
   // item is predicted; the glyph always belongs to an earlier row anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            seen = '{rsp.lead_byte, rsp.mid_byte, rsp.tail_byte, rsp.column, rsp.last};
            board.check_result(seen);
         end
         if (req.valid && req.ready) begin
            taken = '{req.mode, req.cell_x, req.cell_y, req.dot_col, req.dot_row,
                      req.bar_height};
            board.note_input(taken);
         end
      end
   end

   // Hang detector: counts cycles without any item moving on either channel.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Glyph receiver back-pressure: stretches of always-ready, coin-flip,
   // mostly-stalled and a fixed one-in-three stall pattern.
   initial begin
      int hold, style;
      rsp.ready <= 1'b0;
      hold  = 0;
      style = 0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            style = $urandom_range(0, 3);
            hold  = $urandom_range(8, 80);
         end
         hold--;
         case (style)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ((hold % 3) != 0);
         endcase
      end
   end

   // Presents one item and returns at the edge that takes it.
   task automatic send_cmd(canvas_cmd_type c);
      req.valid      <= 1'b1;
      req.mode       <= c.mode;
      req.cell_x     <= c.cell_x;
      req.cell_y     <= c.cell_y;
      req.dot_col    <= c.dot_col;
      req.dot_row    <= c.dot_row;
      req.bar_height <= c.bar_height;
      do @(posedge clock); while (!req.ready);
   endtask

   // Sender pacing: bursts of random length, then a random gap with valid low.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Holds off the sender until every owed glyph has come back.
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (board.glyphs_due.size() != 0) @(posedge clock);
   endtask

   // APB write: setup, then access until pready. Upper data bits are random
   // so that the register masking is exercised too.
   task automatic write_reg(logic idx, logic [6:0] value);
      logic [31:0] data;
      data      = $urandom;
      data[6:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic canvas_cmd_type make_cmd(logic [1:0] mode, int x, int y, logic col,
                                               logic [1:0] row, int bar);
      canvas_cmd_type c;
      c = '{mode, 6'(x), 5'(y), col, row, 8'(bar)};
      return c;
   endfunction

   // Mostly well-formed items inside the current size with random content;
   // the rest is raw noise, which may land out of range or on the unused mode.
   function automatic canvas_cmd_type random_cmd();
      canvas_cmd_type c;
      int             w, h, pick;
      c    = canvas_cmd_type'(24'($urandom));
      w    = board.used_w();
      h    = board.used_h();
      pick = $urandom_range(0, 99);
      if (pick < 38 && w > 0 && h > 0) begin
         c.mode   = MODE_DOT;
         c.cell_x = 6'($urandom_range(0, w - 1));
         c.cell_y = 5'($urandom_range(0, h - 1));
      end else if (pick < 62 && w > 0) begin
         c.mode       = MODE_BAR;
         c.cell_x     = 6'($urandom_range(0, w - 1));
         c.bar_height = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, 4*h + 3));
      end else if (pick < 86 && h > 0) begin
         c.mode   = MODE_ROW;
         c.cell_y = 5'($urandom_range(0, h - 1));
      end else if (pick >= 95) begin
         c.mode = MODE_SPARE;
      end
      return c;
   endfunction

   initial begin
      canvas_cmd_type directed [$];
      board = new();

      // everything the bench drives is known from time zero
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req.valid      <= 1'b0;
      req.mode       <= MODE_DOT;
      req.cell_x     <= '0;
      req.cell_y     <= '0;
      req.dot_col    <= 1'b0;
      req.dot_row    <= '0;
      req.bar_height <= '0;
      burst_left = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a 10 x 6 canvas, written while the clear pass runs.
      write_reg(REG_WIDTH, 7'd10);
      write_reg(REG_HEIGHT, 7'd6);

      // corner cell, bottom-left and top-right dots
      directed = {directed, make_cmd(MODE_DOT, 9, 5, 1'b0, 2'd3, 0)};
      directed = {directed, make_cmd(MODE_DOT, 9, 5, 1'b1, 2'd0, 0)};
      // out of range column, out of range row, both at the field maximum
      directed = {directed, make_cmd(MODE_DOT, 10, 0, 1'b0, 2'd0, 0)};
      directed = {directed, make_cmd(MODE_DOT, 0, 6, 1'b1, 2'd1, 0)};
      directed = {directed, make_cmd(MODE_DOT, 63, 31, 1'b1, 2'd3, 255)};
      // all eight dots of the braille map into one cell
      for (int col = 0; col < 2; col++) begin
         for (int row = 0; row < 4; row++) begin
            directed = {directed, make_cmd(MODE_DOT, 2, 1, 1'(col), 2'(row), 0)};
         end
      end
      // bars: partial cell, too tall (clamped), empty, outside width, exact fit
      directed = {directed, make_cmd(MODE_BAR, 3, 0, 1'b1, 2'd0, 5)};
      directed = {directed, make_cmd(MODE_BAR, 4, 31, 1'b0, 2'd3, 255)};
      directed = {directed, make_cmd(MODE_BAR, 3, 0, 1'b0, 2'd0, 0)};
      directed = {directed, make_cmd(MODE_BAR, 10, 0, 1'b0, 2'd0, 8)};
      directed = {directed, make_cmd(MODE_BAR, 9, 0, 1'b1, 2'd0, 24)};
      directed = {directed, make_cmd(MODE_SPARE, 1, 1, 1'b1, 2'd1, 9)};
      // renders: top, drawn rows, bottom, one past the last row, field maximum
      directed = {directed, make_cmd(MODE_ROW, 0, 0, 1'b0, 2'd0, 0)};
      directed = {directed, make_cmd(MODE_ROW, 0, 1, 1'b0, 2'd0, 0)};
      directed = {directed, make_cmd(MODE_ROW, 63, 5, 1'b1, 2'd3, 255)};
      directed = {directed, make_cmd(MODE_ROW, 0, 6, 1'b0, 2'd0, 0)};
      directed = {directed, make_cmd(MODE_ROW, 0, 31, 1'b0, 2'd0, 0)};

      foreach (directed[k]) begin
         send_cmd(directed[k]);
         pace();
      end

      // Random phases. Cells survive each size change, so old drawings show
      // up again once a later size uncovers them.
      foreach (phase_w[ph]) begin
         settle();
         repeat (DRAIN_CYCLES) @(posedge clock);   // last dot or bar may still be busy
         write_reg(REG_WIDTH, 7'(phase_w[ph]));
         write_reg(REG_HEIGHT, 7'(phase_h[ph]));
         for (int n = 0; n < phase_items[ph]; n++) begin
            if (n == phase_items[ph] / 2) begin
               settle();   // sender waits for a fully drained block mid-phase
            end
            send_cmd(random_cmd());
            pace();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d dots, %0d bars, %0d rows rendered, %0d dropped.",
               board.n_dot + board.n_bar + board.n_row + board.n_ignored,
               board.n_dot, board.n_bar, board.n_row, board.n_ignored);
      $display("%0d glyphs matched over 9 canvas sizes, zero and clamped sizes included.",
               board.n_glyphs);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/bdc_pkg.sv
hdl/bdc_channels.sv
hdl/bdc_csr.sv
hdl/bdc_cell_ram.sv
hdl/bdc_engine.sv
hdl/braille_dot_canvas.sv
test/braille_dot_canvas_tb.sv
